[src/trv_pkg.sv]
package trv_pkg;

	// Accepted sensor family codes (ROM byte 0).
	localparam logic [7:0] FAMILY_A = 8'h10;
	localparam logic [7:0] FAMILY_B = 8'h28;

	// Number of ROM bits covered by the CRC (bytes 0 to 6).
	localparam int CRC_BITS = 56;

	// Reset values of the configuration registers.
	localparam logic signed [15:0] MIN_VALID_RESET    = -16'sd550;
	localparam logic signed [15:0] MAX_VALID_RESET    = 16'sd1250;
	localparam logic        [15:0] MAX_DELTA_RESET    = 16'd50;
	localparam logic signed [15:0] INITIAL_HOLD_RESET = 16'sd250;

	typedef enum logic [1:0] {
		REG_MIN_VALID    = 2'd0,
		REG_MAX_VALID    = 2'd1,
		REG_MAX_DELTA    = 2'd2,
		REG_INITIAL_HOLD = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED      = 3'd0,
		ST_NOT_FOUND     = 3'd1,
		ST_CRC_FAIL      = 3'd2,
		ST_BAD_FAMILY    = 3'd3,
		ST_OUT_OF_RANGE  = 3'd4,
		ST_TOO_RAPID     = 3'd5
	} status_t;

	// The Dallas CRC-8 with a zero seed is linear in the message bits, so each
	// CRC bit is the parity of a fixed subset of the 56 message bits. This
	// function builds those subsets once, at elaboration.
	function automatic logic [7:0][CRC_BITS-1:0] crc8_masks();
		logic [7:0][CRC_BITS-1:0] masks;
		logic [7:0]               crc;
		logic                     mix;
		masks = '0;
		for (int j = 0; j < CRC_BITS; j++) begin
			crc = 8'h00;
			for (int i = 0; i < CRC_BITS; i++) begin
				mix = crc[0] ^ (i == j);
				crc = crc >> 1;
				if (mix) begin
					crc = crc ^ 8'h8C;
				end
			end
			for (int k = 0; k < 8; k++) begin
				masks[k][j] = crc[k];
			end
		end
		return masks;
	endfunction

	localparam logic [7:0][CRC_BITS-1:0] CRC_MASK = crc8_masks();

endpackage

[src/temperature_reading_validator_core.sv]
// Temperature reading validator. Each input transaction is one sensor reading
// attempt (found flag, 64-bit ROM code, raw reading in sixteenths of a degree)
// and produces exactly one output transaction: the held temperature in tenths
// of a degree after that reading, plus a status code. A reading is rejected,
// in this priority, if no sensor was found, if the CRC-8 over ROM bytes 0..6
// does not match ROM byte 7, if the family byte is neither 0x10 nor 0x28, if
// the converted value lies outside [min_valid_tenths, max_valid_tenths], or if
// it differs from the held value by more than max_delta_tenths. Only accepted
// readings replace the held value; the held value starts from the reset value
// of initial_hold_tenths (250), and writing that register later does not reload
// it. The datapath is a three-register pipeline (input register, check
// register, output register), and one transaction can be accepted every
// cycle while the output is not stalled. The held-value compare sits in the
// check stage, so consecutive readings see each other's updates in order.
// Stages with no valid transaction absorb new input even while the output is
// stalled. Configuration is through an APB port with registers at byte
// addresses 0, 4, 8 and 12; pready is always high.
module temperature_reading_validator_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               sensor_found,
	input  logic [63:0]        rom_code,
	input  logic signed [15:0] raw_reading,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temperature_tenths,
	output logic [2:0]         status,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import trv_pkg::*;

	// Configuration registers.
	logic signed [15:0] min_valid_q;
	logic signed [15:0] max_valid_q;
	logic        [15:0] max_delta_q;
	logic signed [15:0] initial_hold_q;

	reg_idx_t reg_idx;
	logic     cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q    <= MIN_VALID_RESET;
			max_valid_q    <= MAX_VALID_RESET;
			max_delta_q    <= MAX_DELTA_RESET;
			initial_hold_q <= INITIAL_HOLD_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_MIN_VALID:    min_valid_q    <= signed'(pwdata[15:0]);
				REG_MAX_VALID:    max_valid_q    <= signed'(pwdata[15:0]);
				REG_MAX_DELTA:    max_delta_q    <= pwdata[15:0];
				REG_INITIAL_HOLD: initial_hold_q <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_VALID:    prdata = {16'h0000, min_valid_q};
			REG_MAX_VALID:    prdata = {16'h0000, max_valid_q};
			REG_MAX_DELTA:    prdata = {16'h0000, max_delta_q};
			REG_INITIAL_HOLD: prdata = {16'h0000, initial_hold_q};
			default:          prdata = 32'h0000_0000;
		endcase
	end

	// Handshake: each stage can take a new transaction when it is empty or
	// when the stage after it is taking its current one.
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic ready_out;
	logic ready_s2;
	logic ready_s1;

	assign ready_out = ~out_valid_q | out_ready;
	assign ready_s2  = ~valid_s2 | ready_out;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = out_valid_q;

	// Stage 1: input register.
	logic               found_s1;
	logic [63:0]        rom_s1;
	logic signed [15:0] raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			found_s1 <= sensor_found;
			rom_s1   <= rom_code;
			raw_s1   <= raw_reading;
		end
	end

	// Stage 1 logic: bus-level checks and unit conversion.
	logic [7:0]         crc_calc;
	logic [7:0]         family;
	status_t            pre_status;
	logic signed [18:0] raw_x5;
	logic signed [18:0] rounded;
	logic signed [15:0] tenths;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			crc_calc[k] = ^(rom_s1[CRC_BITS-1:0] & CRC_MASK[k]);
		end
	end

	assign family = rom_s1[7:0];

	always_comb begin
		if (!found_s1) begin
			pre_status = ST_NOT_FOUND;
		end else if (crc_calc != rom_s1[63:56]) begin
			pre_status = ST_CRC_FAIL;
		end else if (family != FAMILY_A && family != FAMILY_B) begin
			pre_status = ST_BAD_FAMILY;
		end else begin
			pre_status = ST_ACCEPTED;
		end
	end

	// raw * 10 / 16 = raw * 5 / 8, rounded half away from zero. For negative
	// values adding 3 before the arithmetic shift gives the same result as
	// negating, rounding up and negating back.
	assign raw_x5  = (19'(raw_s1) <<< 2) + 19'(raw_s1);
	assign rounded = (raw_x5 + (raw_x5[18] ? 19'sd3 : 19'sd4)) >>> 3;
	assign tenths  = rounded[15:0];

	// Stage 2: check register.
	status_t            pre_status_s2;
	logic signed [15:0] tenths_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			pre_status_s2 <= pre_status;
			tenths_s2     <= tenths;
		end
	end

	// Stage 2 logic: range and rate-of-change checks against the held value.
	logic signed [15:0] held_q;
	logic signed [16:0] diff;
	logic        [16:0] abs_diff;
	logic               out_of_range;
	logic               too_rapid;
	status_t            final_status;
	logic               take_s2;

	assign diff         = 17'(tenths_s2) - 17'(held_q);
	assign abs_diff     = diff[16] ? unsigned'(-diff) : unsigned'(diff);
	assign out_of_range = (tenths_s2 < min_valid_q) || (tenths_s2 > max_valid_q);
	assign too_rapid    = abs_diff > {1'b0, max_delta_q};
	assign take_s2      = valid_s2 & ready_out;

	always_comb begin
		if (pre_status_s2 != ST_ACCEPTED) begin
			final_status = pre_status_s2;
		end else if (out_of_range) begin
			final_status = ST_OUT_OF_RANGE;
		end else if (too_rapid) begin
			final_status = ST_TOO_RAPID;
		end else begin
			final_status = ST_ACCEPTED;
		end
	end

	// The held value only moves when an accepted reading leaves stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= INITIAL_HOLD_RESET;
		end else if (take_s2 && final_status == ST_ACCEPTED) begin
			held_q <= tenths_s2;
		end
	end

	// Output register.
	logic signed [15:0] temperature_q;
	status_t            status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			temperature_q <= (final_status == ST_ACCEPTED) ? tenths_s2 : held_q;
			status_q      <= final_status;
		end
	end

	assign temperature_tenths = temperature_q;
	assign status             = status_q;

endmodule
